[hw/rtl/lcp_pkg.sv]
// Package for the Luce choice probability block: transaction types and constants.
// No dependencies; used by luce_choice_probability and lcp_checker.
package lcp_pkg;

    // Input transaction: two activations for one output element
    typedef struct packed {
        logic signed [15:0] act_first;
        logic signed [15:0] act_second;
        logic               last_element;
    } in_t;

    // Output transaction: probability of the first node
    typedef struct packed {
        logic [15:0] probability;
        logic        invalid;
        logic        last_out;
    } out_t;

    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam logic [15:0] PROB_MAX   = 16'hFFFF;

endpackage

[hw/rtl/lcp_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage, with sideband.
// Depends on nothing; instanced by luce_choice_probability.
module lcp_div_pipe #(
    parameter int NW = 64,   // numerator width
    parameter int DW = 32,   // divisor width
    parameter int QW = 33,   // quotient bits (numerator >> QW must be below divisor)
    parameter int SW = 3     // sideband width
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] div,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          v_reg    [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [DW-1:0] div_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_p;
        logic [DW-1:0] rem_p;
        logic [QW-1:0] low_p;
        logic [QW-1:0] q_p;
        logic [DW-1:0] div_p;
        logic [SW-1:0] side_p;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        // previous stage, or the input for the first one
        if (k == 0) begin : g_first
            assign v_p    = in_valid;
            assign rem_p  = DW'(num[NW-1:QW]);
            assign low_p  = num[QW-1:0];
            assign q_p    = '0;
            assign div_p  = div;
            assign side_p = side_in;
        end else begin : g_next
            assign v_p    = v_reg[k-1];
            assign rem_p  = rem_reg[k-1];
            assign low_p  = low_reg[k-1];
            assign q_p    = q_reg[k-1];
            assign div_p  = div_reg[k-1];
            assign side_p = side_reg[k-1];
        end

        // one trial subtraction
        assign trial = {rem_p, low_p[QW-1]};
        assign diff  = trial - {1'b0, div_p};
        assign ge    = (trial >= {1'b0, div_p});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                low_reg[k]  <= {low_p[QW-2:0], 1'b0};
                q_reg[k]    <= {q_p[QW-2:0], ge};
                div_reg[k]  <= div_p;
                side_reg[k] <= side_p;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

[hw/rtl/luce_choice_probability.sv]
// Luce choice probability top level: base forming, ratio, squarings, final quotient.
// Depends on lcp_pkg and lcp_div_pipe.
//
// Takes one transaction per clock unless the output stalls, and returns one
// result per transaction, in order. The two dividers resolve one quotient bit
// per pipeline stage (33 bits for the magnitude ratio, 17 for the probability).
// A stalled output freezes the whole pipeline; in_stall follows it in the same
// cycle. The gain register is to be written through the cfg port only while the
// block is idle, which the block does not enforce; a write is taken at once.
module luce_choice_probability #(
    parameter int SQUARINGS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  lcp_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output lcp_pkg::out_t out_data
);

    localparam logic signed [33:0] BASE_ONE = 34'sd1 <<< (16 + SQUARINGS);

    logic        adv;
    logic [15:0] gain_reg;

    // gain register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= lcp_pkg::GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            gain_reg <= cfg_data;
        end
    end

    // global advance: only a held result blocks the pipe
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage 1: bases and magnitudes
    logic signed [33:0] b1, b2;
    logic        s1_v_reg, s1_last_reg;
    logic [31:0] s1_m1_reg, s1_m2_reg;

    assign b1 = BASE_ONE + 34'($signed({1'b0, gain_reg}) * in_data.act_first);
    assign b2 = BASE_ONE + 34'($signed({1'b0, gain_reg}) * in_data.act_second);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_m1_reg   <= b1[33] ? 32'(-b1) : b1[31:0];
            s1_m2_reg   <= b2[33] ? 32'(-b2) : b2[31:0];
            s1_last_reg <= in_data.last_element;
        end
    end

    // stage 2: order the magnitudes
    logic        s2_v_reg, s2_fb_reg, s2_inv_reg, s2_last_reg;
    logic [31:0] s2_mn_reg, s2_mx_reg;
    logic        fb_next, inv_next;

    assign fb_next  = (s1_m1_reg >= s1_m2_reg);
    assign inv_next = (s1_m1_reg == '0) && (s1_m2_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_fb_reg   <= fb_next;
            s2_inv_reg  <= inv_next;
            s2_last_reg <= s1_last_reg;
            s2_mn_reg   <= fb_next ? s1_m2_reg : s1_m1_reg;
            // divisor kept nonzero for the undefined case; result forced later
            s2_mx_reg   <= inv_next ? 32'd1 : (fb_next ? s1_m1_reg : s1_m2_reg);
        end
    end

    // ratio divider: t = round(mn * 2^32 / mx)
    logic        r_v;
    logic [32:0] r_q;
    logic [2:0]  r_side;

    lcp_div_pipe #(
        .NW(64), .DW(32), .QW(33), .SW(3)
    ) u_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (s2_v_reg),
        .num      ({s2_mn_reg, 32'd0} + {33'd0, s2_mx_reg[31:1]}),
        .div      (s2_mx_reg),
        .side_in  ({s2_fb_reg, s2_inv_reg, s2_last_reg}),
        .out_valid(r_v),
        .quo      (r_q),
        .side_out (r_side)
    );

    // squaring chain, one squaring per stage
    logic        sq_v_reg    [SQUARINGS];
    logic [32:0] sq_t_reg    [SQUARINGS];
    logic [2:0]  sq_side_reg [SQUARINGS];

    for (genvar k = 0; k < SQUARINGS; k++) begin : g_sq
        logic        v_p;
        logic [32:0] t_p;
        logic [2:0]  side_p;
        logic [63:0] prod;
        logic [64:0] rnd;

        if (k == 0) begin : g_first
            assign v_p    = r_v;
            assign t_p    = r_q;
            assign side_p = r_side;
        end else begin : g_next
            assign v_p    = sq_v_reg[k-1];
            assign t_p    = sq_t_reg[k-1];
            assign side_p = sq_side_reg[k-1];
        end

        assign prod = t_p[31:0] * t_p[31:0];
        assign rnd  = {1'b0, prod} + 65'(64'd1 << 31);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[k] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                // exactly 1.0 stays 1.0
                sq_t_reg[k]    <= t_p[32] ? t_p : rnd[64:32];
                sq_side_reg[k] <= side_p;
            end
        end
    end

    // probability divider: p = round(num / (2^32 + t))
    logic [32:0] t_fin;
    logic [2:0]  fin_side;
    logic [33:0] den;
    logic [49:0] pnum;
    logic        p_v;
    logic [16:0] p_q;
    logic [1:0]  p_side;

    assign t_fin    = sq_t_reg[SQUARINGS-1];
    assign fin_side = sq_side_reg[SQUARINGS-1];
    assign den      = {1'b0, t_fin} + (34'd1 << 32);
    assign pnum     = (fin_side[2] ? (50'd1 << 48) : ({17'd0, t_fin} << 16))
                    + {17'd0, den[33:1]};

    lcp_div_pipe #(
        .NW(50), .DW(34), .QW(17), .SW(2)
    ) u_prob (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (sq_v_reg[SQUARINGS-1]),
        .num      (pnum),
        .div      (den),
        .side_in  (fin_side[1:0]),
        .out_valid(p_v),
        .quo      (p_q),
        .side_out (p_side)
    );

    // output: saturate, force zero when undefined
    assign out_valid            = p_v;
    assign out_data.invalid     = p_side[1];
    assign out_data.last_out    = p_side[0];
    assign out_data.probability = p_side[1] ? 16'd0
                                : (p_q[16] ? lcp_pkg::PROB_MAX : p_q[15:0]);

endmodule

[hw/rtl/lcp_checker.sv]
// Port-level checker for luce_choice_probability, bound to the top level.
// Depends on lcp_pkg and luce_choice_probability.
module lcp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cfg_ready,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input lcp_pkg::out_t out_data
);

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // input stalls only behind a held result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // undefined ratio reports zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.invalid |-> out_data.probability == 16'd0)
        else $error("invalid transaction with nonzero probability");

    // gain register always writable
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg port not ready");

endmodule

bind luce_choice_probability lcp_checker u_lcp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ready(cfg_ready),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
